// File: rtl/gdto_pkg.sv
// ----------------------------------------------------------------------------
// gdto_pkg
// Shared types, codes and constants for the Gregorian date-time offset unit.
// ----------------------------------------------------------------------------
package gdto_pkg;

	localparam int AMT_W  = 16;
	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 14;
	localparam int HOUR_W = 5;
	localparam int OP_W   = 3;
	localparam int STEP_W = 4;
	localparam int DVD_W  = 17;
	localparam int REM_W  = 7;
	localparam int DAYS_W = 18;
	localparam int HRS_W  = 6;
	localparam int IN_W   = 48;
	localparam int OUT_W  = 32;
	localparam int CQ_W   = 27;
	localparam int HQ_W   = 30;

	localparam int CENT_SHIFT  = 19;
	localparam int THIRD_SHIFT = 17;

	localparam logic [YEAR_W-1:0] YEAR_MAX    = 14'd9999;
	localparam logic [MON_W-1:0]  MON_JAN     = 4'd1;
	localparam logic [MON_W-1:0]  MON_DEC     = 4'd12;
	localparam logic [HOUR_W-1:0] HOUR_LAST   = 5'd23;
	localparam logic [REM_W-1:0]  CENT_LAST   = 7'd99;
	localparam logic [DVD_W-1:0]  DIV_HOURS   = 17'd24;
	localparam logic [YEAR_W-1:0] DIV_CENT    = 14'd100;
	localparam logic [12:0]       RECIP_CENT  = 13'd5243;
	localparam logic [15:0]       RECIP_THIRD = 16'd43691;

	typedef enum logic [OP_W-1:0] {
		OP_ADD_DAYS  = 3'd0,
		OP_SUB_DAYS  = 3'd1,
		OP_ADD_HOURS = 3'd2,
		OP_SUB_HOURS = 3'd3,
		OP_ADD_YEARS = 3'd4,
		OP_SUB_YEARS = 3'd5
	} op_t;

	typedef enum logic [3:0] {
		U_NOP,
		U_DIV_Y,
		U_DIV_H,
		U_DIV_STEP,
		U_YSPLIT,
		U_HOUR_SET,
		U_WALK_INIT,
		U_WALK_STEP,
		U_BORROW,
		U_YEAR_OP,
		U_FINISH
	} uop_t;

	typedef enum logic [3:0] {
		C_NEXT,
		C_ALWAYS,
		C_EARLY,
		C_OP_YEAR,
		C_OP_DAYS,
		C_NO_WALK,
		C_WALK_MORE,
		C_NO_BORROW
	} cond_t;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t S_ENTRY       = 4'd0;
	localparam step_t S_WALK        = 4'd9;
	localparam step_t S_WALK_LOOP   = 4'd10;
	localparam step_t S_BORROW_LOOP = 4'd13;
	localparam step_t S_FIN         = 4'd14;
	localparam step_t S_YEAR        = 4'd15;

	typedef struct packed {
		uop_t  uop;
		cond_t cond;
		step_t target;
	} cword_t;

	typedef struct packed {
		logic load;
		uop_t uop;
	} dp_ctl_t;

	typedef struct packed {
		logic early;
		logic op_year;
		logic op_days;
		logic no_walk;
		logic walk_more;
		logic no_borrow;
	} dp_stat_t;

	function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m, input logic leap);
		logic [DAY_W-1:0] r;
		begin
			unique case (m)
				4'd2:                   r = leap ? 5'd29 : 5'd28;
				4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
				default:                r = 5'd31;
			endcase
			return r;
		end
	endfunction

endpackage

// File: rtl/gdto_ucode_rom.sv
// ----------------------------------------------------------------------------
// gdto_ucode_rom
// Control store: one control word per program step.
// ----------------------------------------------------------------------------
module gdto_ucode_rom import gdto_pkg::*; (
	input  step_t  step,
	output cword_t cw
);

	always_comb begin
		unique case (step)
			4'd0:  cw = '{U_NOP,       C_EARLY,     S_FIN};
			4'd1:  cw = '{U_NOP,       C_OP_YEAR,   S_YEAR};
			4'd2:  cw = '{U_DIV_Y,     C_NEXT,      S_ENTRY};
			4'd3:  cw = '{U_DIV_STEP,  C_NEXT,      S_ENTRY};
			4'd4:  cw = '{U_YSPLIT,    C_OP_DAYS,   S_WALK};
			4'd5:  cw = '{U_DIV_H,     C_NEXT,      S_ENTRY};
			4'd6:  cw = '{U_DIV_STEP,  C_NEXT,      S_ENTRY};
			4'd7:  cw = '{U_HOUR_SET,  C_NEXT,      S_ENTRY};
			4'd8:  cw = '{U_NOP,       C_NO_WALK,   S_FIN};
			4'd9:  cw = '{U_WALK_INIT, C_NEXT,      S_ENTRY};
			4'd10: cw = '{U_WALK_STEP, C_WALK_MORE, S_WALK_LOOP};
			4'd11: cw = '{U_NOP,       C_NO_BORROW, S_FIN};
			4'd12: cw = '{U_BORROW,    C_NEXT,      S_ENTRY};
			4'd13: cw = '{U_WALK_STEP, C_WALK_MORE, S_BORROW_LOOP};
			4'd14: cw = '{U_FINISH,    C_NEXT,      S_ENTRY};
			4'd15: cw = '{U_YEAR_OP,   C_ALWAYS,    S_FIN};
		endcase
	end

endmodule

// File: rtl/gdto_datapath.sv
// ----------------------------------------------------------------------------
// gdto_datapath
// Date registers, reciprocal divider, month walker and result register.
// ----------------------------------------------------------------------------
module gdto_datapath import gdto_pkg::*; #(
	parameter int AMOUNT_BITS = 16
) (
	input  logic             clk,
	input  dp_ctl_t          ctl,
	input  logic [IN_W-1:0]  in_data,
	input  logic [OP_W-1:0]  in_op,
	output dp_stat_t         stat,
	output logic [OUT_W-1:0] out_data,
	output logic             out_err
);

	localparam logic [AMT_W-1:0] AMT_MASK = (AMOUNT_BITS >= AMT_W) ? {AMT_W{1'b1}} :
		AMT_W'((64'd1 << AMOUNT_BITS) - 64'd1);

	logic [AMT_W-1:0]  in_amt;
	logic [DAY_W-1:0]  in_day;
	logic [MON_W-1:0]  in_mon;
	logic [YEAR_W-1:0] in_year;
	logic [HOUR_W-1:0] in_hour;

	logic [OP_W-1:0]          op_q;
	logic [DAY_W-1:0]         rd_q;
	logic [MON_W-1:0]         rm_q;
	logic [YEAR_W-1:0]        ry_q;
	logic [HOUR_W-1:0]        rh_q;
	logic [AMT_W-1:0]         n_q;
	logic signed [DAYS_W-1:0] d_q;
	logic [MON_W-1:0]         m_q;
	logic [YEAR_W-1:0]        y_q;
	logic [REM_W-1:0]         yc_q;
	logic [1:0]               yh_q;
	logic signed [HRS_W-1:0]  h_q;
	logic [AMT_W-1:0]         w_q;
	logic                     back_q;
	logic                     err_q;
	logic                     noop_q;
	logic [DVD_W-1:0]         dvd_q;
	logic [AMT_W-1:0]         quo_q;
	logic                     div100_q;

	logic                     leap;
	logic [MON_W-1:0]         m_prev;
	logic [DAY_W-1:0]         md_cur;
	logic [DAY_W-1:0]         md_prev;
	logic signed [DAYS_W-1:0] md_cur_x;
	logic signed [DAYS_W-1:0] md_prev_x;
	logic signed [DAYS_W-1:0] w_x;
	logic                     need_f;
	logic                     need_b;
	logic                     walk_more;
	logic [CQ_W-1:0]          cent_mul;
	logic [HQ_W-1:0]          third_mul;
	logic [YEAR_W-1:0]        cent_rem;
	logic [DVD_W-1:0]         hour_rem;
	logic [DVD_W-1:0]         year_sum;
	logic [DVD_W-1:0]         hour_sum;
	logic signed [HRS_W-1:0]  rem_h;

	assign in_amt  = in_data[15:0];
	assign in_day  = in_data[20:16];
	assign in_mon  = in_data[24:21];
	assign in_year = in_data[38:25];
	assign in_hour = in_data[43:39];

	assign leap      = (yc_q[1:0] == 2'b00) && ((yc_q != '0) || (yh_q == 2'b00));
	assign m_prev    = m_q - 4'd1;
	assign md_cur    = month_days(m_q, leap);
	assign md_prev   = month_days(m_prev, leap);
	assign md_cur_x  = signed'({13'd0, md_cur});
	assign md_prev_x = signed'({13'd0, md_prev});
	assign w_x       = signed'({2'd0, w_q});
	assign need_f    = d_q > md_cur_x;
	assign need_b    = d_q[DAYS_W-1] || (d_q == '0);
	assign walk_more = !err_q && (back_q ? need_b : need_f);

	// x/100 as (x*5243)>>19 for x < 10000; x/24 as ((x>>3)*43691)>>17
	assign cent_mul  = {13'd0, dvd_q[YEAR_W-1:0]} * {14'd0, RECIP_CENT};
	assign third_mul = {16'd0, dvd_q[DVD_W-1:3]} * {14'd0, RECIP_THIRD};
	assign cent_rem  = dvd_q[YEAR_W-1:0] - ({7'd0, quo_q[6:0]} * DIV_CENT);
	assign hour_rem  = dvd_q - ({1'b0, quo_q} * DIV_HOURS);
	assign year_sum  = {3'd0, y_q} + {1'b0, n_q};
	assign hour_sum  = {12'd0, h_q[HOUR_W-1:0]} + {1'b0, n_q};
	assign rem_h     = signed'({1'b0, hour_rem[HOUR_W-1:0]});

	always_comb begin
		stat.early     = err_q || noop_q;
		stat.op_year   = (op_q == OP_ADD_YEARS) || (op_q == OP_SUB_YEARS);
		stat.op_days   = (op_q == OP_ADD_DAYS) || (op_q == OP_SUB_DAYS);
		stat.no_walk   = (op_q == OP_ADD_HOURS) && (w_q == '0);
		stat.walk_more = walk_more;
		stat.no_borrow = err_q || !((op_q == OP_SUB_HOURS) && h_q[HRS_W-1]);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q   <= in_op;
			rd_q   <= in_day;
			rm_q   <= in_mon;
			ry_q   <= in_year;
			rh_q   <= in_hour;
			n_q    <= in_amt & AMT_MASK;
			d_q    <= signed'({13'd0, (in_day == '0) ? 5'd1 : in_day});
			m_q    <= (in_mon == '0) ? MON_JAN : ((in_mon > MON_DEC) ? MON_DEC : in_mon);
			y_q    <= in_year;
			h_q    <= signed'({1'b0, (in_hour > HOUR_LAST) ? HOUR_LAST : in_hour});
			err_q  <= in_year > YEAR_MAX;
			noop_q <= in_op > OP_SUB_YEARS;
		end else begin
			unique case (ctl.uop)
				U_NOP: ;
				U_DIV_Y: begin
					dvd_q    <= {3'd0, y_q};
					div100_q <= 1'b1;
				end
				U_DIV_H: begin
					dvd_q    <= (op_q == OP_ADD_HOURS) ? hour_sum : {1'b0, n_q};
					div100_q <= 1'b0;
				end
				U_DIV_STEP: begin
					quo_q <= div100_q ? {8'd0, cent_mul[CQ_W-1:CENT_SHIFT]} :
						{3'd0, third_mul[HQ_W-1:THIRD_SHIFT]};
				end
				U_YSPLIT: begin
					yc_q   <= cent_rem[REM_W-1:0];
					yh_q   <= quo_q[1:0];
					w_q    <= n_q;
					back_q <= op_q == OP_SUB_DAYS;
				end
				U_HOUR_SET: begin
					w_q <= quo_q;
					if (op_q == OP_ADD_HOURS) begin
						h_q    <= rem_h;
						back_q <= 1'b0;
					end else begin
						h_q    <= h_q - rem_h;
						back_q <= 1'b1;
					end
				end
				U_WALK_INIT: d_q <= back_q ? (d_q - w_x) : (d_q + w_x);
				U_WALK_STEP: begin
					if (walk_more) begin
						if (back_q) begin
							if (m_q == MON_JAN) begin
								if (y_q == '0) begin
									err_q <= 1'b1;
								end else begin
									m_q <= MON_DEC;
									y_q <= y_q - 14'd1;
									d_q <= d_q + 18'sd31;
									if (yc_q == '0) begin
										yc_q <= CENT_LAST;
										yh_q <= yh_q - 2'd1;
									end else begin
										yc_q <= yc_q - 7'd1;
									end
								end
							end else begin
								m_q <= m_prev;
								d_q <= d_q + md_prev_x;
							end
						end else begin
							d_q <= d_q - md_cur_x;
							if (m_q == MON_DEC) begin
								if (y_q == YEAR_MAX) begin
									err_q <= 1'b1;
								end else begin
									m_q <= MON_JAN;
									y_q <= y_q + 14'd1;
									if (yc_q == CENT_LAST) begin
										yc_q <= '0;
										yh_q <= yh_q + 2'd1;
									end else begin
										yc_q <= yc_q + 7'd1;
									end
								end
							end else begin
								m_q <= m_q + 4'd1;
							end
						end
					end
				end
				U_BORROW: begin
					h_q <= h_q + 6'sd24;
					d_q <= d_q - 18'sd1;
				end
				U_YEAR_OP: begin
					if (op_q == OP_ADD_YEARS) begin
						if (year_sum > {3'd0, YEAR_MAX}) err_q <= 1'b1;
						else y_q <= year_sum[YEAR_W-1:0];
					end else begin
						if (n_q > {2'd0, y_q}) err_q <= 1'b1;
						else y_q <= y_q - n_q[YEAR_W-1:0];
					end
				end
				U_FINISH: begin
					out_err <= err_q;
					if (err_q || noop_q) begin
						out_data <= {4'd0, rh_q, ry_q, rm_q, rd_q};
					end else begin
						out_data <= {4'd0, h_q[HOUR_W-1:0], y_q, m_q, d_q[DAY_W-1:0]};
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/gdto_seq.sv
// ----------------------------------------------------------------------------
// gdto_seq
// Step counter, jump logic and stream handshakes.
// ----------------------------------------------------------------------------
module gdto_seq import gdto_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  dp_stat_t stat,
	input  cword_t   cw,
	output step_t    step,
	output dp_ctl_t  ctl
);

	logic  busy_q;
	step_t step_q;
	logic  m_tvalid_q;
	logic  accept;
	logic  is_fin;
	logic  stall;
	logic  exec;
	logic  cond_true;

	assign s_tready = !busy_q;
	assign m_tvalid = m_tvalid_q;
	assign step     = step_q;
	assign accept   = s_tvalid && !busy_q;
	assign is_fin   = cw.uop == U_FINISH;
	assign stall    = is_fin && m_tvalid_q && !m_tready;
	assign exec     = busy_q && !stall;

	always_comb begin
		unique case (cw.cond)
			C_NEXT:      cond_true = 1'b0;
			C_ALWAYS:    cond_true = 1'b1;
			C_EARLY:     cond_true = stat.early;
			C_OP_YEAR:   cond_true = stat.op_year;
			C_OP_DAYS:   cond_true = stat.op_days;
			C_NO_WALK:   cond_true = stat.no_walk;
			C_WALK_MORE: cond_true = stat.walk_more;
			C_NO_BORROW: cond_true = stat.no_borrow;
			default:     cond_true = 1'b0;
		endcase
	end

	always_comb begin
		ctl.load = accept;
		ctl.uop  = exec ? cw.uop : U_NOP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			step_q     <= S_ENTRY;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				step_q <= S_ENTRY;
			end else if (exec) begin
				step_q <= cond_true ? cw.target : step_q + 4'd1;
				if (is_fin) busy_q <= 1'b0;
			end
			if (exec && is_fin) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_rise_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(busy_q && is_fin))
		else $error("result valid without finish step");
	a_fin_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && is_fin && !stall) |=> (!busy_q && m_tvalid_q))
		else $error("finish step did not close item");
	a_accept_entry: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && (step_q == S_ENTRY)))
		else $error("accepted beat did not start program");
`endif

endmodule

// File: rtl/gregorian_date_time_offset_top.sv
// ----------------------------------------------------------------------------
// gregorian_date_time_offset_top
// Adds or subtracts days, hours or years on a Gregorian date-time.
// Program paths (accept to valid): out-of-range input years and unused op codes go
//   straight to the finish step; year ops run the year step; day ops split the year,
//   then walk one month per cycle; hour ops also divide the hours by 24, skip the
//   walk for a short hour add, and after the walk may borrow a day from the hours.
// One item in flight; the next beat is taken the cycle after the result
// is registered.
// Reset: arst_n clears the sequencer and output valid; no memories to clear.
// ----------------------------------------------------------------------------
module gregorian_date_time_offset_top import gdto_pkg::*; #(
	parameter int AMOUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // amount[15:0], day_in, month_in, year_in, hour_in
	input  logic [2:0]  s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // day_out, month_out, year_out, hour_out
	output logic [0:0]  m_tuser    // range_error
);

	dp_stat_t stat;
	dp_ctl_t  ctl;
	cword_t   cw;
	step_t    step;
	logic     out_err;

	assign m_tuser = out_err;

	gdto_ucode_rom u_rom (
		.step (step),
		.cw   (cw)
	);

	gdto_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cw       (cw),
		.step     (step),
		.ctl      (ctl)
	);

	gdto_datapath #(
		.AMOUNT_BITS (AMOUNT_BITS)
	) u_dp (
		.clk      (clk),
		.ctl      (ctl),
		.in_data  (s_tdata),
		.in_op    (s_tuser),
		.stat     (stat),
		.out_data (m_tdata),
		.out_err  (out_err)
	);

endmodule

// File: tb/sv/tb_gregorian_date_time_offset_top.sv
// ----------------------------------------------------------------------------
// tb_gregorian_date_time_offset_top
// Drives date-time shift requests into the offset unit and checks every
// result beat against a local calendar predictor. A directed batch covers
// calendar edges, leap rules, borrow and range-error cases; a random batch
// follows. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_gregorian_date_time_offset_top;
	import gdto_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
	localparam int              LAST_YEAR   = 9999;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [AMT_W-1:0]  amount;
		logic [DAY_W-1:0]  day;
		logic [MON_W-1:0]  month;
		logic [YEAR_W-1:0] year;
		logic [HOUR_W-1:0] hour;
	} shift_req_t;

	typedef struct packed {
		logic [DAY_W-1:0]  day;
		logic [MON_W-1:0]  month;
		logic [YEAR_W-1:0] year;
		logic [HOUR_W-1:0] hour;
		logic              range_err;
	} shift_res_t;

	class date_shift_scoreboard;
		shift_res_t pending_dates[$];
		int         mismatches;

		function new();
			mismatches = 0;
		endfunction

		function int outstanding();
			return pending_dates.size();
		endfunction

		function int days_in_month(int m, int y);
			if (m == 2)
				return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
			if (m == 4 || m == 6 || m == 9 || m == 11)
				return 30;
			return 31;
		endfunction

		function bit walk_ahead(inout int d, inout int m, inout int y, input int n);
			d += n;
			while (d > days_in_month(m, y)) begin
				d -= days_in_month(m, y);
				m++;
				if (m > 12) begin
					m = 1;
					y++;
					if (y > LAST_YEAR)
						return 1'b0;
				end
			end
			return 1'b1;
		endfunction

		function bit walk_back(inout int d, inout int m, inout int y, input int n);
			d -= n;
			while (d <= 0) begin
				m--;
				if (m < 1) begin
					m = 12;
					y--;
					if (y < 0)
						return 1'b0;
				end
				d += days_in_month(m, y);
			end
			return 1'b1;
		endfunction

		function shift_res_t shift_date(shift_req_t r);
			int         d, m, y, h, n, t;
			bit         ok;
			shift_res_t res;
			n  = r.amount;
			d  = (r.day == 0) ? 1 : r.day;
			m  = (r.month == 0) ? 1 : ((r.month > 12) ? 12 : r.month);
			y  = r.year;
			h  = (r.hour > 23) ? 23 : r.hour;
			ok = 1'b1;
			res = '{day: r.day, month: r.month, year: r.year, hour: r.hour, range_err: 1'b0};
			if (r.year > LAST_YEAR) begin
				ok = 1'b0;
			end else if (r.op == OP_SPARE_LO || r.op == OP_SPARE_HI) begin
				return res;
			end else if (r.op == OP_ADD_DAYS) begin
				ok = walk_ahead(d, m, y, n);
			end else if (r.op == OP_SUB_DAYS) begin
				ok = walk_back(d, m, y, n);
			end else if (r.op == OP_ADD_HOURS) begin
				t = h + n;
				h = t % 24;
				if (t / 24 > 0)
					ok = walk_ahead(d, m, y, t / 24);
			end else if (r.op == OP_SUB_HOURS) begin
				ok = walk_back(d, m, y, n / 24);
				h -= n % 24;
				if (ok && h < 0) begin
					h += 24;
					ok = walk_back(d, m, y, 1);
				end
			end else if (r.op == OP_ADD_YEARS) begin
				if (y + n > LAST_YEAR)
					ok = 1'b0;
				else
					y += n;
			end else begin
				if (n > y)
					ok = 1'b0;
				else
					y -= n;
			end
			if (!ok) begin
				res.range_err = 1'b1;
				return res;
			end
			res.day   = d[DAY_W-1:0];
			res.month = m[MON_W-1:0];
			res.year  = y[YEAR_W-1:0];
			res.hour  = h[HOUR_W-1:0];
			return res;
		endfunction

		function void note_request(shift_req_t r);
			pending_dates.push_back(shift_date(r));
		endfunction

		function void check_result(logic [OUT_W-1:0] data, logic [0:0] flag);
			shift_res_t got, want;
			got.day       = data[4:0];
			got.month     = data[8:5];
			got.year      = data[22:9];
			got.hour      = data[27:23];
			got.range_err = flag[0];
			if (pending_dates.size() == 0) begin
				$display("%0t: result beat with none expected: %h / %b", $time, data, flag);
				mismatches++;
				return;
			end
			want = pending_dates.pop_front();
			if (got.day != want.day) begin
				$display("%0t: day_out expected %0d actual %0d", $time, want.day, got.day);
				mismatches++;
			end
			if (got.month != want.month) begin
				$display("%0t: month_out expected %0d actual %0d", $time, want.month, got.month);
				mismatches++;
			end
			if (got.year != want.year) begin
				$display("%0t: year_out expected %0d actual %0d", $time, want.year, got.year);
				mismatches++;
			end
			if (got.hour != want.hour) begin
				$display("%0t: hour_out expected %0d actual %0d", $time, want.hour, got.hour);
				mismatches++;
			end
			if (got.range_err != want.range_err) begin
				$display("%0t: range_error expected %0b actual %0b", $time,
					want.range_err, got.range_err);
				mismatches++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic [OP_W-1:0]   s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic [0:0]        m_tuser;
	logic              steady = 1'b0;

	date_shift_scoreboard sb = new();

	gregorian_date_time_offset_top #(
		.AMOUNT_BITS(16)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 7);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	task automatic send_shift(input logic [OP_W-1:0] op, input int amount, input int d,
			input int m, input int y, input int h);
		shift_req_t r;
		r.op     = op;
		r.amount = amount[AMT_W-1:0];
		r.day    = d[DAY_W-1:0];
		r.month  = m[MON_W-1:0];
		r.year   = y[YEAR_W-1:0];
		r.hour   = h[HOUR_W-1:0];
		if (!steady && $urandom_range(99) < 7) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= r.op;
		s_tdata  <= {4'b0, r.hour, r.year, r.month, r.day, r.amount};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(r);
	endtask

	task automatic send_random_shift();
		int op, amount, d, m, y, h, pick;
		pick = $urandom_range(99);
		op = (pick < 3) ? $urandom_range(7, 6) : $urandom_range(5, 0);
		if (op == OP_ADD_YEARS || op == OP_SUB_YEARS) begin
			amount = ($urandom_range(1)) ? $urandom_range(10000) : $urandom_range(65535);
		end else begin
			pick = $urandom_range(99);
			if (pick < 80)
				amount = $urandom_range(500);
			else if (pick < 94)
				amount = $urandom_range(4000);
			else
				amount = $urandom_range(65535);
		end
		d = ($urandom_range(99) < 80) ? $urandom_range(28, 1) : $urandom_range(31);
		m = ($urandom_range(99) < 90) ? $urandom_range(12, 1) : $urandom_range(15);
		h = ($urandom_range(99) < 90) ? $urandom_range(23) : $urandom_range(31);
		pick = $urandom_range(99);
		if (pick < 70)
			y = $urandom_range(LAST_YEAR);
		else if (pick < 80)
			y = $urandom_range(3);
		else if (pick < 90)
			y = $urandom_range(LAST_YEAR, LAST_YEAR - 3);
		else
			y = $urandom_range(16383);
		send_shift(op[OP_W-1:0], amount, d, m, y, h);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// calendar edges and leap rules
		send_shift(OP_ADD_DAYS,  0,     31, 4,  2023, 5);
		send_shift(OP_ADD_DAYS,  1,     28, 2,  2024, 0);
		send_shift(OP_ADD_DAYS,  1,     28, 2,  1900, 0);
		send_shift(OP_ADD_DAYS,  1,     28, 2,  2000, 0);
		send_shift(OP_ADD_DAYS,  65535, 1,  1,  0,    0);
		send_shift(OP_ADD_DAYS,  1,     31, 12, 9999, 12);
		send_shift(OP_SUB_DAYS,  1,     1,  1,  0,    3);
		send_shift(OP_SUB_DAYS,  65535, 31, 12, 9999, 23);
		// hours: carry, short add on over-long day, borrow
		send_shift(OP_ADD_HOURS, 65535, 31, 12, 9000, 23);
		send_shift(OP_ADD_HOURS, 5,     31, 4,  2023, 10);
		send_shift(OP_SUB_HOURS, 0,     1,  3,  2023, 0);
		send_shift(OP_SUB_HOURS, 25,    1,  3,  2024, 0);
		send_shift(OP_SUB_HOURS, 65535, 15, 6,  100,  0);
		send_shift(OP_SUB_HOURS, 1,     1,  1,  0,    0);
		// years: day kept, both range limits
		send_shift(OP_ADD_YEARS, 1,     29, 2,  2024, 7);
		send_shift(OP_ADD_YEARS, 9999,  1,  1,  0,    0);
		send_shift(OP_ADD_YEARS, 1,     1,  1,  9999, 0);
		send_shift(OP_SUB_YEARS, 9999,  31, 12, 9999, 0);
		send_shift(OP_SUB_YEARS, 1,     1,  1,  0,    0);
		send_shift(OP_SUB_YEARS, 65535, 1,  1,  9999, 0);
		// bad input fields and spare op codes
		send_shift(OP_ADD_DAYS,  3,     1,  1,  16383, 0);
		send_shift(OP_SPARE_LO,  65535, 0,  15, 16383, 31);
		send_shift(OP_SPARE_HI,  12,    31, 0,  10000, 24);
		send_shift(OP_ADD_YEARS, 0,     0,  0,  500,  31);
		send_shift(OP_SUB_DAYS,  0,     0,  15, 2021, 31);

		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);

		for (int i = 0; i < 210; i++) begin
			if (i == 80)
				steady <= 1'b1;
			if (i == 130)
				steady <= 1'b0;
			send_random_shift();
		end
		s_tvalid <= 1'b0;

		while (sb.outstanding() != 0) @(posedge clk);
		repeat (2500) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#(60_000_000);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
